[hdl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window minimum: shared definitions
// Widths, default sizes and reset values used by the interfaces, the cell
// and the top level.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Width of one sample and of one result minimum.
  localparam int SAMPLE_W = 30;

  // Width of the window size register.
  localparam int CFG_W = 7;

  // Default depth of the window.
  localparam int WINDOW_MAX_DEF = 64;

  // Window size after reset.
  localparam int WINDOW_RESET = 1;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

[hdl/swm_in_if.sv]
// ----------------------------------------------------------------------------
// Sliding window minimum: sample channel
// Valid/ready channel that carries one sample word and its last flag.
// ----------------------------------------------------------------------------
interface swm_in_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;
  logic             last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

[hdl/swm_out_if.sv]
// ----------------------------------------------------------------------------
// Sliding window minimum: result channel
// Valid/ready channel that carries one window minimum and its last flag.
// ----------------------------------------------------------------------------
interface swm_out_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t window_min;
  logic             last_out;

  modport source (output valid, output window_min, output last_out, input ready);
  modport sink (input valid, input window_min, input last_out, output ready);
endinterface

[hdl/swm_cell.sv]
// ----------------------------------------------------------------------------
// Sliding window minimum: chain cell
// Holds the minimum over the newest k+1 samples for its position k. On each
// new word it takes the smaller of the new sample and its neighbor's value.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  swm_pkg::sample_t sample,
  input  swm_pkg::sample_t prev_min,
  output swm_pkg::sample_t min_q
);

  // Running minimum, advanced one position per accepted word.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      min_q <= (sample < prev_min) ? sample : prev_min;
    end
  end

endmodule

[hdl/sliding_window_minimum.sv]
// A result word appears in the cycle after its sample is accepted. Throughput:
// one sample word per cycle unless results stall; the path is one tap select
// out of the cell chain and one 30-bit compare into the output register.
// Reset (rst, synchronous) sets the window size to one, empties the sample
// count and drops the output valid; the cell chain needs no clearing pass.
// ----------------------------------------------------------------------------
// Sliding window minimum: top level
// A chain of WINDOW_MAX-1 cells, cell k holding the minimum of the newest
// k+1 samples. For a window of w samples the result is the new sample compared
// against cell w-2 (the new sample alone for w of one), registered on the result channel.
// ----------------------------------------------------------------------------
module sliding_window_minimum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
  swm_in_if.sink                    sample_ch,
  swm_out_if.source                 result_ch
);

  localparam int SW = $clog2(WINDOW_MAX + 1);
  localparam int IW = $clog2(WINDOW_MAX);

  logic [SW-1:0]    eff_win;
  logic [SW-1:0]    eff_win_next;
  logic [IW-1:0]    tap;
  logic             tap_one;
  logic [SW-1:0]    seen_count;
  logic [SW-1:0]    seen_inc;
  logic             in_acc;
  logic             hit;
  swm_pkg::sample_t tap_val;
  swm_pkg::sample_t min_next;
  swm_pkg::sample_t cells [WINDOW_MAX-1];

  // Accept while the output register is empty or being drained.
  assign sample_ch.ready = !result_ch.valid || result_ch.ready;
  assign in_acc = sample_ch.valid && sample_ch.ready;

  // Window size: zero means one, larger than WINDOW_MAX means WINDOW_MAX.
  always_comb begin
    if (cfg_wdata == '0) begin
      eff_win_next = SW'(1);
    end else if (32'(cfg_wdata) > WINDOW_MAX) begin
      eff_win_next = SW'(WINDOW_MAX);
    end else begin
      eff_win_next = SW'(cfg_wdata);
    end
  end

  // Window register with the chain tap that serves it.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_win <= SW'(swm_pkg::WINDOW_RESET);
      tap     <= '0;
      tap_one <= 1'b1;
    end else if (cfg_we) begin
      eff_win <= eff_win_next;
      tap     <= IW'(eff_win_next - SW'(2));
      tap_one <= (eff_win_next == SW'(1));
    end
  end

  // Cell chain; the first cell sees the new sample as its neighbor.
  for (genvar k = 0; k < WINDOW_MAX - 1; k++) begin : g_cell
    swm_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .sample   (sample_ch.sample),
      .prev_min ((k == 0) ? sample_ch.sample : cells[(k == 0) ? 0 : k - 1]),
      .min_q    (cells[k])
    );
  end

  // Sample count of the current sequence, saturating at WINDOW_MAX.
  assign seen_inc = (seen_count < SW'(WINDOW_MAX)) ? seen_count + SW'(1) : seen_count;
  assign hit = (seen_inc >= eff_win);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (in_acc) begin
      seen_count <= sample_ch.last_in ? '0 : seen_inc;
    end
  end

  // Minimum over the window once the new sample is in.
  assign tap_val  = tap_one ? sample_ch.sample : cells[tap];
  assign min_next = (sample_ch.sample < tap_val) ? sample_ch.sample : tap_val;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (sample_ch.ready) begin
      result_ch.valid <= in_acc && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      result_ch.window_min <= min_next;
      result_ch.last_out   <= sample_ch.last_in;
    end
  end

  // The sample count never passes WINDOW_MAX.
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    seen_count <= SW'(WINDOW_MAX))
    else $error("sample count above window depth");

  // A new result comes only from a word accepted in the previous cycle.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_ch.valid) |-> $past(in_acc))
    else $error("result without accepted sample");

  // A last word empties the window.
  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    in_acc && sample_ch.last_in |=> seen_count == '0)
    else $error("window not emptied after last word");

  // An ordinary word advances the count by one below saturation.
  a_seen_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !sample_ch.last_in && (seen_count < SW'(WINDOW_MAX))
    |=> seen_count == $past(seen_count) + SW'(1))
    else $error("sample count did not advance");

  // The window register always stays within one and WINDOW_MAX.
  a_win_range: assert property (@(posedge clk) disable iff (rst)
    (eff_win != '0) && (eff_win <= SW'(WINDOW_MAX)))
    else $error("window size out of range");

endmodule

[bench/swm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window minimum: result checker
// Watches the window size register and both channels, keeps its own copy of
// the sample history, predicts the minimum word once each window is full and
// compares every accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module swm_checker #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata,
  swm_in_if                         sample_ch,
  swm_out_if                        result_ch,
  output int                        fail_count,
  output int                        outstanding
);

  localparam int CW = swm_pkg::CFG_W;

  typedef struct packed {
    swm_pkg::sample_t window_min;
    logic             last_out;
  } min_word_t;

  // Predicted result words, oldest first.
  min_word_t predicted_mins[$];

  // Sample history of the open sequence, entry 0 newest.
  swm_pkg::sample_t history [WINDOW_MAX];
  int unsigned      run_length;
  logic [CW-1:0]    window_reg;

  // A size of zero means one sample; sizes past WINDOW_MAX saturate.
  function automatic int unsigned active_span(logic [CW-1:0] size);
    if (size == '0) return 1;
    if (size > WINDOW_MAX) return WINDOW_MAX;
    return 32'(size);
  endfunction

  // Shift one sample into the history and queue its minimum once the window
  // is full. The last flag closes the sequence either way.
  function automatic void absorb_sample(swm_pkg::sample_t value, logic last);
    int unsigned      span;
    swm_pkg::sample_t lowest;
    span = active_span(window_reg);
    for (int i = WINDOW_MAX - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = value;
    if (run_length < WINDOW_MAX) run_length++;
    if (run_length >= span) begin
      lowest = history[0];
      for (int i = 1; i < span; i++)
        if (history[i] < lowest) lowest = history[i];
      predicted_mins.push_back('{window_min: lowest, last_out: last});
    end
    if (last) run_length = 0;
  endfunction

  // Results are checked before new samples are absorbed, and a register write
  // lands after the sample of the same edge, as it does in the block.
  always @(posedge clk) begin
    min_word_t want;
    if (rst) begin
      predicted_mins.delete();
      foreach (history[i]) history[i] = '0;
      run_length = 0;
      window_reg = CW'(swm_pkg::WINDOW_RESET);
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_mins.size() == 0) begin
          $error("unexpected result word: window_min %0d, last_out %0b",
                 result_ch.window_min, result_ch.last_out);
          fail_count++;
        end else begin
          want = predicted_mins.pop_front();
          if (result_ch.window_min !== want.window_min) begin
            $error("window_min: expected %0d, actual %0d",
                   want.window_min, result_ch.window_min);
            fail_count++;
          end
          if (result_ch.last_out !== want.last_out) begin
            $error("last_out: expected %0b, actual %0b",
                   want.last_out, result_ch.last_out);
            fail_count++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready)
        absorb_sample(sample_ch.sample, sample_ch.last_in);
      if (cfg_we) window_reg = cfg_wdata;
      outstanding <= predicted_mins.size();
    end
  end

endmodule

[bench/sliding_window_minimum_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window minimum: testbench top
// Drives sample words in random bursts through a series of window sizes,
// including zero and sizes beyond the chain depth, with sequences that end
// before the window fills and sequences left open across a size change. The
// result side stalls on its own pattern and once holds off long enough to
// back the block up. The checker beside the block reports the failures.
// ----------------------------------------------------------------------------
module sliding_window_minimum_tb;

  localparam int  CW              = swm_pkg::CFG_W;
  localparam int  TOTAL_WORDS     = 620;
  localparam int  HOLD_OFF_CYCLES = 150;
  localparam int  LATENCY_PAD     = 4;
  localparam int  DRAIN_PAD       = 8;
  localparam real LIMIT_NS        = 2_000_000.0;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;
  int            fail_count;
  int            outstanding;
  int            burst_left;
  int            words_sent;
  bit            hold_off_req;
  bit            hold_off_done;

  swm_in_if  sample_ch ();
  swm_out_if result_ch ();

  sliding_window_minimum uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  swm_checker check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .sample_ch   (sample_ch),
    .result_ch   (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // Result side: stall modes of random length, plus one long hold-off.
  initial begin
    int mode_left;
    int ready_pct;
    bit held;
    result_ch.ready <= 1'b0;
    mode_left = 0;
    ready_pct = 100;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0, 1: ready_pct = 100;
            2: ready_pct = 60;
            default: ready_pct = 25;
          endcase
          mode_left = $urandom_range(5, 40);
        end
        mode_left--;
        result_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // Sample values: extremes, small values that tie often, in-range values
  // and full 30-bit words past the stated range.
  function automatic swm_pkg::sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return swm_pkg::sample_t'(1000000000);
      3, 4: return swm_pkg::sample_t'($urandom_range(0, 15));
      5, 6: return swm_pkg::sample_t'($urandom_range(0, 1000000000));
      default: return swm_pkg::sample_t'($urandom());
    endcase
  endfunction

  // Offer one sample word and wait for it to be taken. A spent burst is
  // followed by a gap with valid low.
  task automatic send_word(swm_pkg::sample_t value, logic last);
    if (burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 12);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.sample  <= value;
    sample_ch.last_in <= last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // A run of random samples, closed with the last flag when asked.
  task automatic send_run(int len, bit close);
    for (int i = 0; i < len; i++) send_word(pick_sample(), close && (i == len - 1));
  endtask

  // Stop offering and wait until every predicted result word has come.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write the window size once the block has gone quiet.
  task automatic load_window(logic [CW-1:0] value);
    drain();
    repeat (LATENCY_PAD) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    logic [CW-1:0] size;
    int            span;
    int            runs;
    int            len;
    bit            open_end;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.sample  <= '0;
    sample_ch.last_in <= 1'b0;
    burst_left    = 0;
    words_sent    = 0;
    hold_off_req  = 1'b0;
    hold_off_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Window of one after reset: extremes and alternating bit patterns.
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(swm_pkg::sample_t'(1000000000), 1'b0);
    send_word(30'h1555_5555, 1'b0);
    send_word(30'h2AAA_AAAA, 1'b1);

    // A sequence shorter than the window, then one where the minimum ages out.
    load_window(3);
    send_word(4, 1'b0);
    send_word(2, 1'b1);
    send_word(9, 1'b0);
    send_word(5, 1'b0);
    send_word(7, 1'b0);
    send_word(8, 1'b0);
    send_word(2, 1'b1);

    // A size of zero acts as a window of one.
    load_window(0);
    send_word(6, 1'b0);
    send_word(3, 1'b1);

    // An oversized window left open, then shrunk in the middle of the sequence.
    load_window(65);
    send_word(12, 1'b0);
    send_word(1, 1'b0);
    send_word(14, 1'b0);
    load_window(2);
    send_word(11, 1'b0);
    send_word(10, 1'b1);

    // Random phases, mostly small windows with the odd extreme size.
    while (words_sent < TOTAL_WORDS) begin
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 5))
            0: size = 0;
            1: size = 1;
            2: size = 63;
            3: size = 64;
            4: size = 65;
            default: size = 127;
          endcase
        end
        1: size = CW'($urandom_range(0, 127));
        default: size = CW'($urandom_range(1, 12));
      endcase
      load_window(size);
      span = (size == 0) ? 1 :
             (size > swm_pkg::WINDOW_MAX_DEF) ? swm_pkg::WINDOW_MAX_DEF : 32'(size);

      // Once, with a narrow window, the result side holds off while a long
      // run keeps coming, so the block backs up onto its input.
      if (!hold_off_done && span <= 4) begin
        hold_off_req  = 1'b1;
        hold_off_done = 1'b1;
        send_run(40, 1'b1);
      end

      runs = (span > 16) ? 1 : $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
        if (span > 1 && $urandom_range(0, 4) == 0)
          len = $urandom_range(1, span - 1);
        else
          len = span + $urandom_range(0, 12);
        open_end = (r == runs - 1) && ($urandom_range(0, 5) == 0);
        send_run(len, !open_end);
      end
    end

    drain();
    repeat (DRAIN_PAD) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
